// File: hdl/bounded_set_table_defines.svh
// Assertion macros used by the checker file of the bounded set table.
// Depends on nothing; each macro expects clk and rst in scope.
`ifndef BOUNDED_SET_TABLE_DEFINES_SVH
`define BOUNDED_SET_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SBT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/sbt_pkg.sv
// Shared types and codes of the bounded set table.
// Used by the front, back and top-level modules; depends on nothing.
package sbt_pkg;

  localparam int COUNT_W = 6;
  localparam int VALUE_W = 32;
  localparam int CMD_W   = 2;

  // Largest count the 6-bit count field can show.
  localparam int MAX_COUNT = (2 ** COUNT_W) - 1;

  localparam logic [COUNT_W-1:0] CAP_RESET = 6'd32;

  // Command codes as they arrive on the request channel.
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  // Classified operations carried through the queue.
  typedef logic [1:0] op_t;
  localparam op_t OP_LOOKUP = 2'd0;
  localparam op_t OP_ADD    = 2'd1;
  localparam op_t OP_REMOVE = 2'd2;

  typedef struct packed {
    op_t                op;
    logic [VALUE_W-1:0] value;
  } req_t;

endpackage

// File: hdl/bounded_set_table.sv
// Top level of the bounded set table: capacity register, front queue and
// back execution unit. Depends on sbt_pkg, sbt_front and sbt_back.
//
// Usage:
// - Requests (cmd, value) enter on in_valid/in_ready. Command 0 looks up,
//   1 adds and 2 removes a value; the unused code acts as a lookup.
// - Each request gives one result (was_member, ok, count) on
//   out_valid/out_ready, in request order.
// - The capacity register is written on cfg_valid/cfg_ready with cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
// - The back unit takes a new request only once it is through with the last:
//   it registers the compare over all entries, then updates the table and
//   the result register; the update waits while a result is held unread.
// - Behind a waiting result up to three more requests are held: one in the
//   back unit and two in the queue between the input and the back unit.
// - When out_ready stays low the result holds, the back unit waits, and
//   in_ready drops once the queue is full.
// - Reset empties the table and the queue, drops out_valid and sets the
//   capacity to 32. Entries are not cleared; the compare masks out empty slots.
module bounded_set_table
  import sbt_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               was_member,
  output logic               ok,
  output logic [COUNT_W-1:0] count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [COUNT_W-1:0] cfg_data
);

  // Lanes actually used: the count never exceeds what its field can show.
  localparam int NUM = (DEPTH < MAX_COUNT) ? DEPTH : MAX_COUNT;

  logic               q_valid;
  logic               q_ready;
  req_t               q_req;
  logic [COUNT_W-1:0] capacity;

  // Capacity register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  sbt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .value    (value),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_req    (q_req)
  );

  sbt_back #(
    .N (NUM)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .capacity   (capacity),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_req      (q_req),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .was_member (was_member),
    .ok         (ok),
    .count      (count)
  );

endmodule

// File: hdl/sbt_front.sv
// Front part of the bounded set table: accepts requests, classifies the
// command and holds them in a two-entry queue. Depends on sbt_pkg.
module sbt_front
  import sbt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   cmd,
  input  logic [VALUE_W-1:0] value,
  output logic               q_valid,
  input  logic               q_ready,
  output req_t               q_req
);

  req_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  op_t        op_dec;
  logic       push;
  logic       pop;

  // Map the command to an operation; the unused code acts as a lookup.
  always_comb begin
    unique case (cmd)
      CMD_ADD:    op_dec = OP_ADD;
      CMD_REMOVE: op_dec = OP_REMOVE;
      default:    op_dec = OP_LOOKUP;
    endcase
  end

  assign in_ready = (fill != 2'd2);
  assign q_valid  = (fill != 2'd0);
  assign q_req    = slots[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  // Queue storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{op: op_dec, value: value};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// File: hdl/sbt_back.sv
// Back part of the bounded set table: compares a request against all held
// entries, then appends, shifts out or leaves the table. Depends on sbt_pkg.
module sbt_back
  import sbt_pkg::*;
#(
  parameter int N = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COUNT_W-1:0] capacity,
  input  logic               q_valid,
  output logic               q_ready,
  input  req_t               q_req,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               was_member,
  output logic               ok,
  output logic [COUNT_W-1:0] count
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic               state;
  logic               state_next;
  logic [VALUE_W-1:0] entries [N];
  logic [COUNT_W-1:0] held;
  logic [COUNT_W-1:0] held_next;
  op_t                cur_op;
  logic [VALUE_W-1:0] cur_value;
  logic [N-1:0]       hit;
  logic [N-1:0]       hit_next;
  logic [N-1:0]       shift;
  logic [COUNT_W-1:0] limit;
  logic               member;
  logic               room;
  logic               do_append;
  logic               do_remove;
  logic               fail;
  logic               fire;
  logic               out_valid_r;
  logic               was_member_r;
  logic               ok_r;
  logic [COUNT_W-1:0] count_r;

  assign q_ready = (state == S_IDLE);

  // Compare lanes: one per entry, masked by the fill level.
  always_comb begin
    for (int i = 0; i < N; i++) begin
      hit_next[i] = (entries[i] == q_req.value) && (COUNT_W'(i) < held);
    end
  end

  // Every lane at or above the hit takes the entry above it on a remove.
  always_comb begin
    shift[0] = hit[0];
    for (int i = 1; i < N; i++) begin
      shift[i] = shift[i-1] | hit[i];
    end
  end

  // Decide the operation outcome.
  assign member    = |hit;
  assign limit     = (capacity < COUNT_W'(N)) ? capacity : COUNT_W'(N);
  assign room      = (held < limit);
  assign do_append = (cur_op == OP_ADD) && !member && room;
  assign do_remove = (cur_op == OP_REMOVE) && member;
  assign fail      = (cur_op == OP_ADD) && !member && !room;
  assign fire      = (state == S_EXEC) && (!out_valid_r || out_ready);

  always_comb begin
    held_next = held;
    if (do_append) begin
      held_next = held + COUNT_W'(1);
    end else if (do_remove) begin
      held_next = held - COUNT_W'(1);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      held        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        held        <= held_next;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Latch the popped request together with its compare result.
  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      cur_op    <= q_req.op;
      cur_value <= q_req.value;
      hit       <= hit_next;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      was_member_r <= member;
      ok_r         <= !fail;
      count_r      <= held_next;
    end
  end

  // Entry lanes: append at the fill level or take the next entry on a remove.
  for (genvar g = 0; g < N; g++) begin : g_lane
    logic [VALUE_W-1:0] upper;
    if (g < N - 1) begin : g_up
      assign upper = entries[g+1];
    end else begin : g_top
      assign upper = entries[g];
    end
    always_ff @(posedge clk) begin
      if (fire) begin
        if (do_append && (held == COUNT_W'(g))) begin
          entries[g] <= cur_value;
        end else if (do_remove && shift[g]) begin
          entries[g] <= upper;
        end
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign was_member = was_member_r;
  assign ok         = ok_r;
  assign count      = count_r;

endmodule

// File: hdl/sbt_checker.sv
// Port-level checks of the bounded set table and the bind that attaches them.
// Depends on sbt_pkg and bounded_set_table_defines.svh.
`include "bounded_set_table_defines.svh"

module sbt_checker
  import sbt_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               was_member,
  input logic               ok,
  input logic [COUNT_W-1:0] count
);

  // A stalled result stays valid.
  `SBT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its fields.
  `SBT_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable({was_member, ok, count}), "result changed while stalled")

  // Only an add of an absent value can fail.
  `SBT_ASSERT_IMPL(a_fail_absent, out_valid && !ok, !was_member, "failure reported for a present value")

  // No result is pending right after reset.
  `SBT_ASSERT_IMPL(a_reset_idle, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind bounded_set_table sbt_checker u_sbt_checker (.*);
